/* rtl/core/rsgc_pkg.sv */
package rsgc_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int STAMP_WIDTH    = 32;
  localparam int COUNT_WIDTH    = 32;
  localparam int CFG_WIDTH      = 16;
  localparam int CFG_IDX_WIDTH  = 3;

  // Item kinds.
  localparam logic [1:0] ACT_INIT   = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_ACK    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LAMP_TEST = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_RELEASE   = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DEBOUNCE  = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_REPEAT    = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ACK_AGE   = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LOSS      = 3'd5;

  // Configuration reset values, in milliseconds.
  localparam logic [CFG_WIDTH-1:0] LAMP_TEST_RST = 16'd2000;
  localparam logic [CFG_WIDTH-1:0] RELEASE_RST   = 16'd100;
  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [CFG_WIDTH-1:0] REPEAT_RST    = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] ACK_AGE_RST   = 16'd300;
  localparam logic [CFG_WIDTH-1:0] LOSS_RST      = 16'd1000;

  // Command codes.
  localparam logic [1:0] CMD_READY = 2'd0;
  localparam logic [1:0] CMD_GO    = 2'd1;
  localparam logic [1:0] CMD_ESTOP = 2'd2;

  // E-stop causes.
  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_WIRE = 2'd1;
  localparam logic [1:0] CAUSE_LOSS = 2'd2;

  typedef enum logic [1:0] {
    PH_LAMP    = 2'd0,
    PH_STANDBY = 2'd1,
    PH_GO      = 2'd2,
    PH_ESTOP   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] lamp_test_time;
    logic [CFG_WIDTH-1:0] release_time;
    logic [CFG_WIDTH-1:0] debounce_time;
    logic [CFG_WIDTH-1:0] repeat_time;
    logic [CFG_WIDTH-1:0] ack_max_age;
    logic [CFG_WIDTH-1:0] loss_latch_time;
  } cfg_t;

  typedef struct packed {
    logic [1:0]             command;
    logic [1:0]             phase_code;
    logic [1:0]             estop_cause;
    logic [COUNT_WIDTH-1:0] go_count;
    logic                   go_rejected;
    logic                   link_fresh;
    logic                   run_allowed;
  } result_t;

endpackage

/* rtl/core/remote_estop_go_controller.sv */
// Channel  | Handshake               | Payload
// ---------+-------------------------+----------------------------------------------
// input    | in_valid / in_stall     | action, now_time, go_button, shut_open
// output   | out_valid / out_stall   | command, phase_code, estop_cause, go_count,
//          |                         | go_rejected, link_fresh, run_allowed
// config   | cfg_we (no wait)        | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall stays low; each item passes through
// the input register and then through the state update into the result register.
// Synchronous reset clears all state; the controller starts in lamp test.
// A result waiting under out_stall holds; the input register stays full behind it
// and in_stall rises only when both registers are occupied.
module remote_estop_go_controller
  import rsgc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               action,
  input  logic [STAMP_WIDTH-1:0]   now_time,
  input  logic                     go_button,
  input  logic                     shut_open,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               command,
  output logic [1:0]               phase_code,
  output logic [1:0]               estop_cause,
  output logic [COUNT_WIDTH-1:0]   go_count,
  output logic                     go_rejected,
  output logic                     link_fresh,
  output logic                     run_allowed,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]     cfg_data
);

  cfg_t                  cfg;
  logic                  s1_valid;
  logic [1:0]            s1_action;
  logic [TIME_WIDTH-1:0] s1_now;
  logic                  s1_go;
  logic                  s1_shut;
  logic                  advance;
  logic                  take;
  result_t               step_result;
  result_t               res;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign take     = in_valid && !in_stall;

  rsgc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take || (s1_valid && !advance);
    end
  end

  // The timestamp is taken modulo the time width here.
  always_ff @(posedge clk) begin
    if (take) begin
      s1_action <= action;
      s1_now    <= TIME_WIDTH'(now_time);
      s1_go     <= go_button;
      s1_shut   <= shut_open;
    end
  end

  rsgc_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (advance),
    .action     (s1_action),
    .now        (s1_now),
    .go_button  (s1_go),
    .shut_open  (s1_shut),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_result;
    end
  end

  assign command     = res.command;
  assign phase_code  = res.phase_code;
  assign estop_cause = res.estop_cause;
  assign go_count    = res.go_count;
  assign go_rejected = res.go_rejected;
  assign link_fresh  = res.link_fresh;
  assign run_allowed = res.run_allowed;

endmodule

/* rtl/core/rsgc_cfg.sv */
module rsgc_cfg
  import rsgc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]     cfg_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lamp_test_time  <= LAMP_TEST_RST;
      cfg.release_time    <= RELEASE_RST;
      cfg.debounce_time   <= DEBOUNCE_RST;
      cfg.repeat_time     <= REPEAT_RST;
      cfg.ack_max_age     <= ACK_AGE_RST;
      cfg.loss_latch_time <= LOSS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAMP_TEST: cfg.lamp_test_time  <= cfg_data;
        REG_RELEASE:   cfg.release_time    <= cfg_data;
        REG_DEBOUNCE:  cfg.debounce_time   <= cfg_data;
        REG_REPEAT:    cfg.repeat_time     <= cfg_data;
        REG_ACK_AGE:   cfg.ack_max_age     <= cfg_data;
        REG_LOSS:      cfg.loss_latch_time <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/rsgc_core.sv */
module rsgc_core
  import rsgc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  item_valid,
  input  logic [1:0]            action,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic                  go_button,
  input  logic                  shut_open,
  output result_t               result
);

  phase_t                  phase, phase_next;
  logic [TIME_WIDTH-1:0]   phase_since, phase_since_next;
  logic [1:0]              latched_reason, latched_reason_next;
  logic                    authorized, authorized_next;
  logic [TIME_WIDTH-1:0]   last_ack_time, last_ack_time_next;
  logic                    acked_once, acked_once_next;
  logic                    release_timing, release_timing_next;
  logic [TIME_WIDTH-1:0]   release_since, release_since_next;
  logic                    armed, armed_next;
  logic                    press_timing, press_timing_next;
  logic [TIME_WIDTH-1:0]   press_since, press_since_next;
  logic                    rejected_flag, rejected_flag_next;
  logic [COUNT_WIDTH-1:0]  start_count, start_count_next;

  logic [TIME_WIDTH-1:0]   phase_age, ack_age, release_age, press_age;
  logic                    fresh_now;

  // Elapsed times wrap at the timestamp width.
  assign phase_age   = now - phase_since;
  assign ack_age     = now - last_ack_time;
  assign release_age = now - release_since;
  assign press_age   = now - press_since;
  assign fresh_now   = acked_once && (ack_age <= TIME_WIDTH'(cfg.ack_max_age));

  always_comb begin
    logic go_on;
    logic entered_go;
    logic rep_hit;
    go_on                = 1'b0;
    entered_go           = 1'b0;
    rep_hit              = 1'b0;
    phase_next           = phase;
    phase_since_next     = phase_since;
    latched_reason_next  = latched_reason;
    authorized_next      = authorized;
    last_ack_time_next   = last_ack_time;
    acked_once_next      = acked_once;
    release_timing_next  = release_timing;
    release_since_next   = release_since;
    armed_next           = armed;
    press_timing_next    = press_timing;
    press_since_next     = press_since;
    rejected_flag_next   = rejected_flag;
    start_count_next     = start_count;

    case (action)
      ACT_INIT: begin
        phase_next          = PH_LAMP;
        phase_since_next    = now;
        latched_reason_next = CAUSE_NONE;
        authorized_next     = 1'b0;
        last_ack_time_next  = '0;
        acked_once_next     = 1'b0;
        release_timing_next = 1'b0;
        release_since_next  = '0;
        armed_next          = 1'b0;
        press_timing_next   = 1'b0;
        press_since_next    = '0;
        rejected_flag_next  = 1'b0;
        start_count_next    = '0;
        if (shut_open) begin
          phase_next          = PH_ESTOP;
          latched_reason_next = CAUSE_WIRE;
        end
      end
      ACT_SAMPLE: begin
        if (phase == PH_ESTOP) begin
          go_on = 1'b0;
        end else if (shut_open) begin
          phase_next          = PH_ESTOP;
          phase_since_next    = now;
          latched_reason_next = CAUSE_WIRE;
          authorized_next     = 1'b0;
        end else if (authorized && acked_once &&
                     (ack_age > TIME_WIDTH'(cfg.loss_latch_time))) begin
          phase_next          = PH_ESTOP;
          phase_since_next    = now;
          latched_reason_next = CAUSE_LOSS;
          authorized_next     = 1'b0;
        end else begin
          go_on = 1'b1;
          if (phase == PH_LAMP) begin
            if (phase_age < TIME_WIDTH'(cfg.lamp_test_time)) begin
              go_on = 1'b0;
            end else begin
              phase_next       = PH_STANDBY;
              phase_since_next = now;
            end
          end
        end

        if (go_on) begin
          if (!go_button) begin
            press_timing_next = 1'b0;
            if (!release_timing) begin
              release_timing_next = 1'b1;
              release_since_next  = now;
            end else if (release_age >= TIME_WIDTH'(cfg.release_time)) begin
              armed_next         = 1'b1;
              rejected_flag_next = 1'b0;
            end
          end else begin
            release_timing_next = 1'b0;
            if (armed) begin
              if (!press_timing) begin
                press_timing_next = 1'b1;
                press_since_next  = now;
              end else if (press_age >= TIME_WIDTH'(cfg.debounce_time)) begin
                armed_next        = 1'b0;
                press_timing_next = 1'b0;
                if (fresh_now) begin
                  phase_next       = PH_GO;
                  phase_since_next = now;
                  authorized_next  = 1'b1;
                  start_count_next = start_count + COUNT_WIDTH'(1);
                  entered_go       = 1'b1;
                end else begin
                  rejected_flag_next = 1'b1;
                end
              end
            end
          end

          // A go that just started has an age of zero.
          rep_hit = entered_go ? (cfg.repeat_time == '0)
                               : (phase_age >= TIME_WIDTH'(cfg.repeat_time));
          if (phase_next == PH_GO && rep_hit) begin
            phase_next       = PH_STANDBY;
            phase_since_next = now;
          end
        end
      end
      ACT_ACK: begin
        last_ack_time_next = now;
        acked_once_next    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LAMP;
      phase_since    <= '0;
      latched_reason <= CAUSE_NONE;
      authorized     <= 1'b0;
      last_ack_time  <= '0;
      acked_once     <= 1'b0;
      release_timing <= 1'b0;
      release_since  <= '0;
      armed          <= 1'b0;
      press_timing   <= 1'b0;
      press_since    <= '0;
      rejected_flag  <= 1'b0;
      start_count    <= '0;
    end else if (item_valid) begin
      phase          <= phase_next;
      phase_since    <= phase_since_next;
      latched_reason <= latched_reason_next;
      authorized     <= authorized_next;
      last_ack_time  <= last_ack_time_next;
      acked_once     <= acked_once_next;
      release_timing <= release_timing_next;
      release_since  <= release_since_next;
      armed          <= armed_next;
      press_timing   <= press_timing_next;
      press_since    <= press_since_next;
      rejected_flag  <= rejected_flag_next;
      start_count    <= start_count_next;
    end
  end

  // The result reports the state after the item; freshness is judged at its timestamp.
  always_comb begin
    case (phase_next)
      PH_ESTOP: result.command = CMD_ESTOP;
      PH_GO:    result.command = CMD_GO;
      default:  result.command = CMD_READY;
    endcase
    result.phase_code  = phase_next;
    result.estop_cause = latched_reason_next;
    result.go_count    = start_count_next;
    result.go_rejected = rejected_flag_next;
    result.run_allowed = authorized_next;
    case (action)
      ACT_INIT: result.link_fresh = 1'b0;
      ACT_ACK:  result.link_fresh = 1'b1;
      default:  result.link_fresh = fresh_now;
    endcase
  end

  a_estop_not_authorized: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ESTOP) |-> !authorized)
    else $error("authorization held while e-stop is latched");

  a_reason_matches_phase: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ESTOP) == (latched_reason != CAUSE_NONE))
    else $error("latched reason disagrees with phase");

  a_press_needs_arm: assert property (@(posedge clk) disable iff (rst)
    press_timing |-> (armed && !release_timing))
    else $error("press timing without an armed button");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (start_count == $past(start_count) ||
              start_count == $past(start_count) + COUNT_WIDTH'(1) ||
              start_count == '0))
    else $error("go count jumped");

endmodule

/* tb/estop_go_checker.sv */
module estop_go_checker
  import rsgc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [1:0]               action,
  input  logic [STAMP_WIDTH-1:0]   now_time,
  input  logic                     go_button,
  input  logic                     shut_open,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [1:0]               command,
  input  logic [1:0]               phase_code,
  input  logic [1:0]               estop_cause,
  input  logic [COUNT_WIDTH-1:0]   go_count,
  input  logic                     go_rejected,
  input  logic                     link_fresh,
  input  logic                     run_allowed,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]     cfg_data,
  output int                       fail_count,
  output int                       pending
);

  cfg_t timing;

  phase_t                 phase_q;
  logic [STAMP_WIDTH-1:0] phase_since_q;
  logic [1:0]             cause_q;
  logic                   authorized_q;
  logic [STAMP_WIDTH-1:0] last_ack_q;
  logic                   ack_seen_q;
  logic                   release_timing_q;
  logic [STAMP_WIDTH-1:0] release_since_q;
  logic                   armed_q;
  logic                   press_timing_q;
  logic [STAMP_WIDTH-1:0] press_since_q;
  logic                   rejected_q;
  logic [COUNT_WIDTH-1:0] go_total_q;

  result_t expected_results[$];
  int mismatch_total = 0;
  int outstanding = 0;

  assign fail_count = mismatch_total;
  assign pending    = outstanding;

  // Timestamps wrap, so every age is a modular difference.
  function automatic logic [STAMP_WIDTH-1:0] elapsed(input logic [STAMP_WIDTH-1:0] now,
                                                     input logic [STAMP_WIDTH-1:0] then_t);
    return now - then_t;
  endfunction

  function automatic void clear_controller();
    phase_q          = PH_LAMP;
    phase_since_q    = '0;
    cause_q          = CAUSE_NONE;
    authorized_q     = 1'b0;
    last_ack_q       = '0;
    ack_seen_q       = 1'b0;
    release_timing_q = 1'b0;
    release_since_q  = '0;
    armed_q          = 1'b0;
    press_timing_q   = 1'b0;
    press_since_q    = '0;
    rejected_q       = 1'b0;
    go_total_q       = '0;
  endfunction

  function automatic void reset_controller();
    timing.lamp_test_time  = LAMP_TEST_RST;
    timing.release_time    = RELEASE_RST;
    timing.debounce_time   = DEBOUNCE_RST;
    timing.repeat_time     = REPEAT_RST;
    timing.ack_max_age     = ACK_AGE_RST;
    timing.loss_latch_time = LOSS_RST;
    clear_controller();
  endfunction

  function automatic void write_timing(input logic [CFG_IDX_WIDTH-1:0] idx,
                                       input logic [CFG_WIDTH-1:0] data);
    case (idx)
      REG_LAMP_TEST: timing.lamp_test_time  = data;
      REG_RELEASE:   timing.release_time    = data;
      REG_DEBOUNCE:  timing.debounce_time   = data;
      REG_REPEAT:    timing.repeat_time     = data;
      REG_ACK_AGE:   timing.ack_max_age     = data;
      REG_LOSS:      timing.loss_latch_time = data;
      default: ;
    endcase
  endfunction

  function automatic void latch_estop(input logic [STAMP_WIDTH-1:0] now, input logic [1:0] cause);
    if (phase_q != PH_ESTOP) begin
      phase_q       = PH_ESTOP;
      phase_since_q = now;
      cause_q       = cause;
      authorized_q  = 1'b0;
    end
  endfunction

  function automatic logic link_is_fresh(input logic [STAMP_WIDTH-1:0] now);
    return ack_seen_q &&
           (elapsed(now, last_ack_q) <= STAMP_WIDTH'(timing.ack_max_age));
  endfunction

  function automatic void take_sample(input logic [STAMP_WIDTH-1:0] now,
                                      input logic go, input logic shut);
    if (shut) latch_estop(now, CAUSE_WIRE);
    if (phase_q == PH_ESTOP) return;
    if (authorized_q && ack_seen_q &&
        elapsed(now, last_ack_q) > STAMP_WIDTH'(timing.loss_latch_time)) begin
      latch_estop(now, CAUSE_LOSS);
      return;
    end
    if (phase_q == PH_LAMP) begin
      if (elapsed(now, phase_since_q) < STAMP_WIDTH'(timing.lamp_test_time)) return;
      phase_q       = PH_STANDBY;
      phase_since_q = now;
    end
    if (!go) begin
      press_timing_q = 1'b0;
      if (!release_timing_q) begin
        release_timing_q = 1'b1;
        release_since_q  = now;
      end else if (elapsed(now, release_since_q) >= STAMP_WIDTH'(timing.release_time)) begin
        armed_q    = 1'b1;
        rejected_q = 1'b0;
      end
    end else begin
      release_timing_q = 1'b0;
      if (armed_q) begin
        if (!press_timing_q) begin
          press_timing_q = 1'b1;
          press_since_q  = now;
        end else if (elapsed(now, press_since_q) >= STAMP_WIDTH'(timing.debounce_time)) begin
          armed_q        = 1'b0;
          press_timing_q = 1'b0;
          if (link_is_fresh(now)) begin
            phase_q       = PH_GO;
            phase_since_q = now;
            authorized_q  = 1'b1;
            go_total_q    = go_total_q + COUNT_WIDTH'(1);
          end else begin
            rejected_q = 1'b1;
          end
        end
      end
    end
    if (phase_q == PH_GO &&
        elapsed(now, phase_since_q) >= STAMP_WIDTH'(timing.repeat_time)) begin
      phase_q       = PH_STANDBY;
      phase_since_q = now;
    end
  endfunction

  function automatic result_t predict_controller(input logic [1:0] act,
                                                 input logic [STAMP_WIDTH-1:0] now,
                                                 input logic go, input logic shut);
    result_t r;
    case (act)
      ACT_INIT: begin
        clear_controller();
        phase_since_q = now;
        if (shut) latch_estop(now, CAUSE_WIRE);
      end
      ACT_SAMPLE: take_sample(now, go, shut);
      ACT_ACK: begin
        last_ack_q = now;
        ack_seen_q = 1'b1;
      end
      default: ;
    endcase
    r.command     = (phase_q == PH_ESTOP) ? CMD_ESTOP :
                    (phase_q == PH_GO) ? CMD_GO : CMD_READY;
    r.phase_code  = phase_q;
    r.estop_cause = cause_q;
    r.go_count    = go_total_q;
    r.go_rejected = rejected_q;
    r.link_fresh  = link_is_fresh(now);
    r.run_allowed = authorized_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_total += 1;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      reset_controller();
      expected_results.delete();
    end else begin
      if (cfg_we) write_timing(cfg_index, cfg_data);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no item outstanding, expected none, got command %0h",
                   $time, command);
          mismatch_total += 1;
        end else begin
          want = expected_results.pop_front();
          check_field("command", 32'(want.command), 32'(command));
          check_field("phase_code", 32'(want.phase_code), 32'(phase_code));
          check_field("estop_cause", 32'(want.estop_cause), 32'(estop_cause));
          check_field("go_count", 32'(want.go_count), 32'(go_count));
          check_field("go_rejected", 32'(want.go_rejected), 32'(go_rejected));
          check_field("link_fresh", 32'(want.link_fresh), 32'(link_fresh));
          check_field("run_allowed", 32'(want.run_allowed), 32'(run_allowed));
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_controller(action, now_time, go_button, shut_open));
    end
    outstanding = expected_results.size();
  end

endmodule

/* tb/testbench.sv */
module testbench;
  import rsgc_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 80;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               action = ACT_INIT;
  logic [STAMP_WIDTH-1:0]   now_time = '0;
  logic                     go_button = 1'b0;
  logic                     shut_open = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               command;
  logic [1:0]               phase_code;
  logic [1:0]               estop_cause;
  logic [COUNT_WIDTH-1:0]   go_count;
  logic                     go_rejected;
  logic                     link_fresh;
  logic                     run_allowed;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = REG_LAMP_TEST;
  logic [CFG_WIDTH-1:0]     cfg_data = '0;
  int                       fail_count;
  int                       pending;

  int send_idle_pct = 23;
  int recv_idle_pct = 48;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  logic [STAMP_WIDTH-1:0] clock_ms = '0;

  remote_estop_go_controller u_top (.*);

  estop_go_checker u_checker (.*);

  always #10 clk = ~clk;

  // The long hold lets the block fill both of its registers and stall its input.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left -= 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [STAMP_WIDTH-1:0] stamp,
                           input logic go, input logic shut);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    now_time  <= stamp;
    go_button <= go;
    shut_open <= shut;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_timing(input cfg_t t);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_LAMP_TEST;
    cfg_data  <= t.lamp_test_time;
    @(negedge clk);
    cfg_index <= REG_RELEASE;
    cfg_data  <= t.release_time;
    @(negedge clk);
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= t.debounce_time;
    @(negedge clk);
    cfg_index <= REG_REPEAT;
    cfg_data  <= t.repeat_time;
    @(negedge clk);
    cfg_index <= REG_ACK_AGE;
    cfg_data  <= t.ack_max_age;
    @(negedge clk);
    cfg_index <= REG_LOSS;
    cfg_data  <= t.loss_latch_time;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Short timings relative to the session step keep the controller cycling through go.
  function automatic cfg_t small_timing();
    cfg_t t;
    t.lamp_test_time  = 16'($urandom_range(100));
    t.release_time    = 16'($urandom_range(40));
    t.debounce_time   = 16'($urandom_range(40));
    t.repeat_time     = 16'($urandom_range(150));
    t.ack_max_age     = 16'($urandom_range(120, 40));
    t.loss_latch_time = 16'($urandom_range(200, 60));
    return t;
  endfunction

  // Runs under the reset timing: lamp test, arming, a rejected press, two accepted
  // presses, link loss, wire open, a timestamp wrap and the unused action code.
  task automatic run_directed();
    send_item(ACT_SAMPLE, 32'd0, 1'b0, 1'b0);
    send_item(ACT_SPARE, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_item(ACT_INIT, 32'd1000, 1'b0, 1'b0);
    send_item(ACT_SAMPLE, 32'd2500, 1'b0, 1'b0);
    send_item(ACT_SAMPLE, 32'd3000, 1'b0, 1'b0);
    send_item(ACT_ACK, 32'd3050, 1'b1, 1'b1);
    send_item(ACT_SAMPLE, 32'd3100, 1'b0, 1'b0);
    send_item(ACT_SAMPLE, 32'd3110, 1'b1, 1'b0);
    send_item(ACT_SAMPLE, 32'd3160, 1'b1, 1'b0);
    send_item(ACT_SAMPLE, 32'd4200, 1'b0, 1'b0);
    send_item(ACT_SAMPLE, 32'd4210, 1'b0, 1'b1);
    send_item(ACT_INIT, 32'hFFFF_FF00, 1'b0, 1'b1);
    send_item(ACT_INIT, 32'hFFFF_FF00, 1'b1, 1'b0);
    send_item(ACT_SAMPLE, 32'h0000_0700, 1'b0, 1'b0);
    send_item(ACT_SAMPLE, 32'h0000_0770, 1'b0, 1'b0);
    send_item(ACT_SAMPLE, 32'h0000_0780, 1'b1, 1'b0);
    send_item(ACT_SAMPLE, 32'h0000_07C0, 1'b1, 1'b0);
    send_item(ACT_SAMPLE, 32'h0000_07D0, 1'b0, 1'b0);
    send_item(ACT_SAMPLE, 32'h0000_0840, 1'b0, 1'b0);
    send_item(ACT_ACK, 32'h0000_0850, 1'b0, 1'b0);
    send_item(ACT_SAMPLE, 32'h0000_0860, 1'b1, 1'b0);
    send_item(ACT_SAMPLE, 32'h0000_0900, 1'b1, 1'b0);
    send_item(ACT_ACK, 32'h0000_0C00, 1'b0, 1'b0);
    send_item(ACT_SAMPLE, 32'h0000_0D00, 1'b0, 1'b0);
    send_item(ACT_SAMPLE, 32'h0000_0D10, 1'b0, 1'b1);
  endtask

  // A session is an init followed mostly by samples with the GO button held in runs
  // and regular acks; the rest is noise: spare actions, jumps, stale stamps, restarts.
  task automatic run_session(input int count, input int unsigned step_max);
    int unsigned roll;
    logic held;
    held = 1'b0;
    clock_ms = $urandom();
    send_item(ACT_INIT, clock_ms, 1'($urandom_range(1)), $urandom_range(99) < 5);
    for (int i = 1; i < count; i++) begin
      roll = $urandom_range(99);
      clock_ms += $urandom_range(step_max);
      if ($urandom_range(99) < 20) held = ~held;
      if (roll < 28) begin
        send_item(ACT_ACK, clock_ms, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (roll < 90) begin
        send_item(ACT_SAMPLE, clock_ms, held, $urandom_range(199) == 0);
      end else if (roll < 93) begin
        send_item(ACT_SPARE, $urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (roll < 96) begin
        clock_ms = $urandom();
        send_item(ACT_SAMPLE, clock_ms, held, 1'b0);
      end else if (roll < 98) begin
        clock_ms -= $urandom_range(step_max);
        send_item(ACT_SAMPLE, clock_ms, held, 1'b0);
      end else begin
        send_item(ACT_INIT, clock_ms, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    run_directed();
    program_timing(small_timing());
    run_session(120, 20);
    program_timing('0);
    run_session(60, 3);

    send_idle_pct = 48;
    recv_idle_pct = 23;
    program_timing(small_timing());
    hold_req = 1'b1;
    run_session(120, 20);
    program_timing('1);
    run_session(60, 25000);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_timing(cfg_t'({$urandom(), $urandom(), $urandom()}));
    run_session(60, 20000);
    program_timing(small_timing());
    run_session(150, 20);

    settle();
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/rsgc_pkg.sv
rtl/core/rsgc_cfg.sv
rtl/core/rsgc_core.sv
rtl/core/remote_estop_go_controller.sv
tb/estop_go_checker.sv
tb/testbench.sv
